// File: rtl/pgp_packet_key_grouper_macros.svh
// -----------------------------------------------------------------------------
// pgp_packet_key_grouper_macros.svh
// Assertion macros shared by the key grouper checks.
// -----------------------------------------------------------------------------
`ifndef PGP_PACKET_KEY_GROUPER_MACROS_SVH
`define PGP_PACKET_KEY_GROUPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGPKG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PGPKG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pgpkg_pkg.sv
// -----------------------------------------------------------------------------
// pgpkg_pkg
// Types, constants and helpers for the OpenPGP packet key grouper.
// -----------------------------------------------------------------------------
package pgpkg_pkg;

    localparam int OFFSET_BITS = 32;

    localparam logic [5:0] KEY_TAG_RESET    = 6'd6;
    localparam logic [7:0] NEW_LEN_TWO_BYTE = 8'd192;
    localparam logic [7:0] NEW_LEN_PARTIAL  = 8'd224;
    localparam logic [7:0] NEW_LEN_FIVE     = 8'd255;

    localparam logic [1:0] OLD_LEN_ONE   = 2'd0;
    localparam logic [1:0] OLD_LEN_TWO   = 2'd1;
    localparam logic [1:0] OLD_LEN_INDET = 2'd3;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_MULTI,
        PH_NEW1,
        PH_NEW2,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        ST_RECORD     = 2'd0,
        ST_BAD_TAG    = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_TRUNCATED  = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [31:0] group_start;
        logic [31:0] group_length;
        logic [15:0] group_index;
        logic        end_of_stream;
    } t_result;

    function automatic logic [31:0] to_out32(input logic [OFFSET_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

endpackage

// File: rtl/pgpkg_parser.sv
// -----------------------------------------------------------------------------
// pgpkg_parser
// Packet header walker and key group tracker; one byte per step.
// -----------------------------------------------------------------------------
module pgpkg_parser
    import pgpkg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic [5:0] i_key_tag,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    t_phase                 r_phase, n_phase;
    logic [2:0]             r_len_left, n_len_left;
    logic [31:0]            r_acc, n_acc;
    logic [31:0]            r_body, n_body;
    logic [OFFSET_BITS-1:0] r_open_start, n_open_start;
    logic [OFFSET_BITS-1:0] r_open_len, n_open_len;
    logic [15:0]            r_groups, n_groups;
    logic                   r_halted, n_halted;

    logic        is_err;
    t_status     err_code;
    logic        pending;
    logic [5:0]  tag;
    logic [31:0] acc_sh;
    logic        do_start;
    logic [31:0] body_len;

    always_comb begin
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_len_left   = r_len_left;
        n_acc        = r_acc;
        n_body       = r_body;
        n_open_start = r_open_start;
        n_open_len   = r_open_len;
        n_groups     = r_groups;
        n_halted     = r_halted;
        is_err       = 1'b0;
        err_code     = ST_RECORD;
        pending      = 1'b0;
        tag          = '0;
        acc_sh       = {r_acc[23:0], i_byte};
        do_start     = 1'b0;
        body_len     = '0;
        o_res_valid  = 1'b0;
        o_res        = '{ST_RECORD, 32'd0, 32'd0, 16'd0, 1'b0};

        if (!r_halted) begin
            unique case (r_phase)
                PH_TAG: begin
                    if (!i_byte[7]) begin
                        is_err   = 1'b1;
                        err_code = ST_BAD_TAG;
                    end else if (i_byte[6]) begin
                        tag     = i_byte[5:0];
                        n_phase = PH_NEW1;
                    end else begin
                        tag = {2'b00, i_byte[5:2]};
                        if (i_byte[1:0] == OLD_LEN_INDET) begin
                            is_err   = 1'b1;
                            err_code = ST_BAD_LENGTH;
                        end else begin
                            n_len_left = (i_byte[1:0] == OLD_LEN_ONE) ? 3'd1 :
                                         (i_byte[1:0] == OLD_LEN_TWO) ? 3'd2 : 3'd4;
                            n_acc      = '0;
                            n_phase    = PH_MULTI;
                        end
                    end
                    if (!is_err && tag == i_key_tag) begin
                        pending      = (r_open_len != '0);
                        n_open_start = r_pos;
                        n_open_len   = '0;
                    end
                end
                PH_MULTI: begin
                    n_acc = acc_sh;
                    if (r_len_left != '0) begin
                        n_len_left = r_len_left - 3'd1;
                    end
                    if (n_len_left == '0) begin
                        do_start = 1'b1;
                        body_len = acc_sh;
                    end
                end
                PH_NEW1: begin
                    if (i_byte < NEW_LEN_TWO_BYTE) begin
                        do_start = 1'b1;
                        body_len = 32'(i_byte);
                    end else if (i_byte < NEW_LEN_PARTIAL) begin
                        n_acc   = {19'd0, i_byte[4:0], 8'd0};
                        n_phase = PH_NEW2;
                    end else if (i_byte != NEW_LEN_FIVE) begin
                        is_err   = 1'b1;
                        err_code = ST_BAD_LENGTH;
                    end else begin
                        n_acc      = '0;
                        n_len_left = 3'd4;
                        n_phase    = PH_MULTI;
                    end
                end
                PH_NEW2: begin
                    do_start = 1'b1;
                    body_len = r_acc + 32'(i_byte) + 32'(NEW_LEN_TWO_BYTE);
                end
                PH_BODY: begin
                    if (r_body != '0) begin
                        n_body = r_body - 32'd1;
                    end
                    if (n_body == '0) begin
                        n_phase = PH_TAG;
                    end
                end
                default: begin
                    n_phase = PH_TAG;
                end
            endcase

            if (do_start) begin
                if (body_len == '0) begin
                    n_phase = PH_TAG;
                end else begin
                    n_body  = body_len;
                    n_phase = PH_BODY;
                end
            end

            if (is_err) begin
                n_halted    = 1'b1;
                o_res_valid = 1'b1;
                o_res       = '{err_code, to_out32(r_pos), 32'd0, r_groups, 1'b1};
            end else begin
                if (n_open_len != '1) begin
                    n_open_len = n_open_len + OFFSET_BITS'(1);
                end
                if (r_pos != '1) begin
                    n_pos = r_pos + OFFSET_BITS'(1);
                end
                if (i_last) begin
                    o_res_valid = 1'b1;
                    if (n_phase != PH_TAG) begin
                        o_res = '{ST_TRUNCATED, to_out32(r_pos), 32'd0, r_groups, 1'b1};
                    end else begin
                        o_res = '{ST_RECORD, to_out32(n_open_start), to_out32(n_open_len),
                                  r_groups, 1'b1};
                    end
                end else if (pending) begin
                    o_res_valid = 1'b1;
                    o_res       = '{ST_RECORD, to_out32(r_open_start), to_out32(r_open_len),
                                    r_groups, 1'b0};
                    if (r_groups != '1) begin
                        n_groups = r_groups + 16'd1;
                    end
                end
            end
        end

        // drop all stream state at end of stream
        if (i_last) begin
            n_pos        = '0;
            n_phase      = PH_TAG;
            n_len_left   = '0;
            n_acc        = '0;
            n_body       = '0;
            n_open_start = '0;
            n_open_len   = '0;
            n_groups     = '0;
            n_halted     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_phase      <= PH_TAG;
            r_len_left   <= '0;
            r_acc        <= '0;
            r_body       <= '0;
            r_open_start <= '0;
            r_open_len   <= '0;
            r_groups     <= '0;
            r_halted     <= 1'b0;
        end else if (i_step) begin
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_len_left   <= n_len_left;
            r_acc        <= n_acc;
            r_body       <= n_body;
            r_open_start <= n_open_start;
            r_open_len   <= n_open_len;
            r_groups     <= n_groups;
            r_halted     <= n_halted;
        end
    end

endmodule

// File: rtl/pgp_packet_key_grouper.sv
// -----------------------------------------------------------------------------
// pgp_packet_key_grouper
// Walks an OpenPGP keyring byte stream and reports one record per key group.
//
// Accepts one stream byte per clock unless a result is stalled in the output
// register. The byte lands in an input register; the header walker updates
// its state and fills the result register from it, so the rate is set by
// that single state update per byte. The input side keeps taking bytes while
// a result waits in the output register as long as the waiting byte yields
// no result. A record is emitted when a key packet closes a non-empty group
// and on the last byte of the stream; a bad tag, an indeterminate or partial
// length, or a stream that ends inside a packet gives one error result, after
// which bytes are ignored up to the end of the stream. The key tag register
// may be written only while no byte is in flight.
// -----------------------------------------------------------------------------
module pgp_packet_key_grouper
    import pgpkg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_key_packet_tag,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_group_start,
    output logic [31:0] o_group_length,
    output logic [15:0] o_group_index,
    output logic        o_end_of_stream
);

    logic [5:0] r_key_tag;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       res_valid;
    t_result    res;
    logic       out_free;
    logic       step;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;
    assign step        = r_in_valid && (!res_valid || out_free);
    assign o_in_ready  = !r_in_valid || step;

    pgpkg_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_key_tag   (r_key_tag),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_tag <= KEY_TAG_RESET;
        end else if (i_cfg_valid) begin
            r_key_tag <= i_cfg_key_packet_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_group_start   = r_out.group_start;
    assign o_group_length  = r_out.group_length;
    assign o_group_index   = r_out.group_index;
    assign o_end_of_stream = r_out.end_of_stream;

endmodule

// File: rtl/pgpkg_checker.sv
// -----------------------------------------------------------------------------
// pgpkg_checker
// Port-level checks for the key grouper, bound to the top level.
// -----------------------------------------------------------------------------
`include "pgp_packet_key_grouper_macros.svh"

module pgpkg_checker
    import pgpkg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_key_packet_tag,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  o_status,
    input  logic [31:0] o_group_start,
    input  logic [31:0] o_group_length,
    input  logic [15:0] o_group_index,
    input  logic        o_end_of_stream
);

    `PGPKG_ASSERT_NOW(a_err_ends_stream, i_clk, i_rst_n,
        o_out_valid && o_status != ST_RECORD, o_end_of_stream,
        "error result without end of stream")

    `PGPKG_ASSERT_NOW(a_err_zero_length, i_clk, i_rst_n,
        o_out_valid && o_status != ST_RECORD, o_group_length == 32'd0,
        "error result with nonzero group length")

    `PGPKG_ASSERT_NOW(a_mid_record_nonempty, i_clk, i_rst_n,
        o_out_valid && !o_end_of_stream, o_status == ST_RECORD && o_group_length != 32'd0,
        "mid-stream result is not a nonempty group record")

    `PGPKG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_status) && $stable(o_group_start)
            && $stable(o_group_length) && $stable(o_group_index)
            && $stable(o_end_of_stream),
        "stalled result beat changed")

endmodule

bind pgp_packet_key_grouper pgpkg_checker u_pgpkg_checker (.*);
